@@ hdl/stepper_step_dir_generator_top_assert.svh @@
// Assertion macros shared by the step/dir generator RTL.
// Relies on clk_i and rst_ni being visible where a macro is used.
`ifndef STEPPER_STEP_DIR_GENERATOR_TOP_ASSERT_SVH
`define STEPPER_STEP_DIR_GENERATOR_TOP_ASSERT_SVH

// checked only outside reset
`define SDG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// checked at every edge, reset included
`define SDG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ hdl/sdg_pkg.sv @@
// Package of the step/dir generator: defaults, command codes, divider types.
// No dependencies.
package sdg_pkg;

  localparam int unsigned POSITION_BITS_DEF    = 32;
  localparam int unsigned MIN_PERIOD_TICKS_DEF = 4;
  localparam int unsigned PULSE_TICKS_DEF      = 2;

  // period divider: numerator < 2^48, quotient < 2^36
  localparam int unsigned DIV_NUM_W = 48;
  localparam int unsigned DIV_QUO_W = 36;

  // 2 * 1e6 * 2^16
  localparam logic [DIV_NUM_W-1:0] PERIOD_NUM_X2 = 48'd131072000000;

  localparam logic [15:0]        SPR_RESET      = 16'd200;
  localparam logic signed [31:0] KEPT_VEL_RESET = 32'sd65536;

  typedef enum logic [2:0] {
    FUNC_TICK     = 3'd0,
    FUNC_ABS      = 3'd1,
    FUNC_REL      = 3'd2,
    FUNC_RUN      = 3'd3,
    FUNC_ABS_KEPT = 3'd4,
    FUNC_REL_KEPT = 3'd5
  } func_e;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_NUM_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_QUO_W-1:0] quo;
  } div_rsp_t;

endpackage

@@ hdl/sdg_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle, for the step period.
// Depends on sdg_pkg (widths, request/response structs).
module sdg_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sdg_pkg::div_req_t req_i,
  output sdg_pkg::div_rsp_t rsp_o
);
  import sdg_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_QUO_W + 1);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [DIV_NUM_W-1:0] rem_q, rem_d;
  logic [DIV_NUM_W-1:0] den_q, den_d;
  logic [DIV_QUO_W-1:0] quo_q, quo_d;
  logic [DIV_NUM_W:0]   trial;
  logic                 fits;

  always_comb begin
    trial  = {rem_q, quo_q[DIV_QUO_W-1]};
    fits   = trial >= {1'b0, den_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      // quotient fits in DIV_QUO_W bits, so the upper numerator bits are below den
      rem_d  = DIV_NUM_W'(req_i.num >> DIV_QUO_W);
      quo_d  = req_i.num[DIV_QUO_W-1:0];
      den_d  = req_i.den;
      cnt_d  = CNT_W'(DIV_QUO_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (fits) begin
        rem_d = DIV_NUM_W'(trial - {1'b0, den_q});
      end else begin
        rem_d = trial[DIV_NUM_W-1:0];
      end
      quo_d = {quo_q[DIV_QUO_W-2:0], fits};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

@@ hdl/stepper_step_dir_generator_top.sv @@
// Step/direction generator top level: command sequencer, shared multiplier, state.
// Depends on sdg_pkg, sdg_div and the assertion macro header.
//
// Usage:
//  - Input channel (in_valid_i/in_ready_o): func_i, rotations_i, velocity_i.
//    func 0 is a one-microsecond tick; 1..5 are move/run commands.
//  - Output channel (out_valid_o/out_ready_i): exactly one result per input
//    transaction, showing pins, position and active period after the item.
//  - Config channel (cfg_valid_i/cfg_ready_o): steps per rotation, always ready;
//    write it only while the block is idle.
//  - Path to the result: tick or unused code passes the start and output states; a
//    stop decision may also pass rotation and check; a command that sets a period
//    waits on the 36-step one-bit-per-cycle divider, skipped at zero steps per rotation.
//  - One item at a time: in_ready_o is high only in the idle state, so a new
//    item waits until the sequencer has passed on the last result.
//  - The result sits in an output register; a new item is accepted while it
//    waits, and the following result holds in the sequencer until taken.
//  - Reset: position, target, period, phase and pins clear, stored velocity
//    is 1.0 rotation per second, steps per rotation is 200.
`include "stepper_step_dir_generator_top_assert.svh"

module stepper_step_dir_generator_top #(
  parameter int unsigned POSITION_BITS    = sdg_pkg::POSITION_BITS_DEF,
  parameter int unsigned MIN_PERIOD_TICKS = sdg_pkg::MIN_PERIOD_TICKS_DEF,
  parameter int unsigned PULSE_TICKS      = sdg_pkg::PULSE_TICKS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [15:0]        cfg_steps_per_rev_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         func_i,
  input  logic signed [31:0] rotations_i,
  input  logic signed [31:0] velocity_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               step_level_o,
  output logic               dir_level_o,
  output logic signed [31:0] position_o,
  output logic               moving_o,
  output logic [31:0]        period_us_o
);
  import sdg_pkg::*;

  localparam int unsigned PB = POSITION_BITS;
  localparam int unsigned PW = $clog2(PULSE_TICKS + 1);
  localparam logic signed [PB-1:0] POS_MAX = {1'b0, {(PB-1){1'b1}}};
  localparam logic signed [PB-1:0] POS_MIN = {1'b1, {(PB-1){1'b0}}};
  localparam logic [32:0]          POS_MAX_U = {{(33-PB){1'b0}}, POS_MAX};
  localparam logic [31:0]          MIN_P = 32'(MIN_PERIOD_TICKS);
  localparam logic [PW-1:0]        PULSE_LD = PW'(PULSE_TICKS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_ROT,
    S_CHECK,
    S_DIVSTART,
    S_DIV,
    S_OUT
  } state_e;

  state_e               state_q, state_d;
  logic [15:0]          spr_q, spr_d;
  logic signed [PB-1:0] pos_q, pos_d;
  logic signed [PB-1:0] tgt_q, tgt_d;
  logic [31:0]          act_q, act_d;
  logic [31:0]          phase_q, phase_d;
  logic [PW-1:0]        pulse_q, pulse_d;
  logic                 step_q, step_d;
  logic                 dir_q, dir_d;
  logic signed [31:0]   kept_q, kept_d;
  logic                 out_valid_q, out_valid_d;

  // payload registers
  logic [2:0]           func_q, func_d;
  logic signed [31:0]   rot_q, rot_d;
  logic signed [31:0]   v_q, v_d;
  logic signed [PB-1:0] cand_q, cand_d;
  logic [47:0]          prod_q, prod_d;
  logic                 o_step_q, o_step_d;
  logic                 o_dir_q, o_dir_d;
  logic signed [31:0]   o_pos_q, o_pos_d;
  logic                 o_mov_q, o_mov_d;
  logic [31:0]          o_per_q, o_per_d;

  logic [31:0]          rot_mag, v_mag, mul_a;
  logic [47:0]          mul_p;
  logic [48:0]          round_sum;
  logic [32:0]          s_mag;
  logic signed [PB-1:0] steps, rel_t;
  logic [PB:0]          rel_sum;
  logic [31:0]          quo_sat, p_new;
  div_req_t             div_req;
  div_rsp_t             div_rsp;

  sdg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // shared multiplier: rotations magnitude first, velocity magnitude later
  assign rot_mag = rot_q[31] ? (~rot_q + 32'd1) : rot_q;
  assign v_mag   = v_q[31] ? (~v_q + 32'd1) : v_q;
  assign mul_a   = (state_q == S_START) ? rot_mag : v_mag;
  assign mul_p   = mul_a * spr_q;

  // rotations to steps, round half away from zero, saturate
  always_comb begin
    round_sum = {1'b0, prod_q} + 49'd32768;
    s_mag     = round_sum[48:16];
    if (!rot_q[31]) begin
      steps = (s_mag > POS_MAX_U) ? POS_MAX : s_mag[PB-1:0];
    end else if (s_mag > POS_MAX_U + 33'd1) begin
      steps = POS_MIN;
    end else begin
      steps = -s_mag[PB-1:0];
    end
    rel_sum = {pos_q[PB-1], pos_q} + {steps[PB-1], steps};
    if (rel_sum[PB] != rel_sum[PB-1]) begin
      rel_t = rel_sum[PB] ? POS_MIN : POS_MAX;
    end else begin
      rel_t = rel_sum[PB-1:0];
    end
  end

  always_comb begin
    quo_sat = (div_rsp.quo[DIV_QUO_W-1:32] != '0) ? '1 : div_rsp.quo[31:0];
    if (prod_q == '0) begin
      p_new = '1;
    end else if (quo_sat < MIN_P) begin
      p_new = MIN_P;
    end else begin
      p_new = quo_sat;
    end
  end

  assign div_req.start = (state_q == S_DIVSTART) && (prod_q != '0);
  assign div_req.num   = PERIOD_NUM_X2 + prod_q;
  assign div_req.den   = {prod_q[46:0], 1'b0};

  always_comb begin
    state_d     = state_q;
    spr_d       = spr_q;
    pos_d       = pos_q;
    tgt_d       = tgt_q;
    act_d       = act_q;
    phase_d     = phase_q;
    pulse_d     = pulse_q;
    step_d      = step_q;
    dir_d       = dir_q;
    kept_d      = kept_q;
    out_valid_d = out_valid_q && !out_ready_i;
    func_d      = func_q;
    rot_d       = rot_q;
    v_d         = v_q;
    cand_d      = cand_q;
    prod_d      = prod_q;
    o_step_d    = o_step_q;
    o_dir_d     = o_dir_q;
    o_pos_d     = o_pos_q;
    o_mov_d     = o_mov_q;
    o_per_d     = o_per_q;

    if (cfg_valid_i) begin
      spr_d = cfg_steps_per_rev_i;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          func_d = func_i;
          rot_d  = rotations_i;
          if (func_i == FUNC_ABS_KEPT || func_i == FUNC_REL_KEPT) begin
            v_d = kept_q;
          end else begin
            v_d = velocity_i;
          end
          state_d = S_START;
        end
      end
      S_START: begin
        prod_d  = mul_p;
        state_d = S_OUT;
        case (func_e'(func_q))
          FUNC_TICK: begin
            if (pulse_q != '0) begin
              pulse_d = pulse_q - PW'(1);
              if (pulse_q == PW'(1)) begin
                step_d = 1'b0;
              end
            end
            if (act_q != '0) begin
              if ({1'b0, phase_q} + 33'd1 >= {1'b0, act_q}) begin
                phase_d = '0;
                if (tgt_q == pos_q) begin
                  act_d = '0;
                end else begin
                  step_d  = 1'b1;
                  pulse_d = PULSE_LD;
                  if (!dir_q) begin
                    if (pos_q != POS_MIN) begin
                      pos_d = pos_q - PB'(1);
                    end
                  end else if (pos_q != POS_MAX) begin
                    pos_d = pos_q + PB'(1);
                  end
                end
              end else begin
                phase_d = phase_q + 32'd1;
              end
            end
          end
          FUNC_ABS, FUNC_REL, FUNC_ABS_KEPT, FUNC_REL_KEPT: begin
            state_d = S_ROT;
          end
          FUNC_RUN: begin
            if (v_q == '0) begin
              kept_d  = '0;
              act_d   = '0;
              phase_d = '0;
              tgt_d   = pos_q;
            end else begin
              cand_d  = v_q[31] ? POS_MIN : POS_MAX;
              state_d = S_CHECK;
            end
          end
          default: begin
            state_d = S_OUT;
          end
        endcase
      end
      S_ROT: begin
        if (func_q == FUNC_REL || func_q == FUNC_REL_KEPT) begin
          cand_d = rel_t;
        end else begin
          cand_d = steps;
        end
        state_d = S_CHECK;
      end
      S_CHECK: begin
        prod_d = mul_p;
        if (cand_q == pos_q || v_q == '0) begin
          kept_d  = '0;
          act_d   = '0;
          phase_d = '0;
          tgt_d   = pos_q;
          state_d = S_OUT;
        end else begin
          tgt_d   = cand_q;
          dir_d   = cand_q > pos_q;
          state_d = S_DIVSTART;
        end
      end
      S_DIVSTART: begin
        if (prod_q == '0) begin
          // no steps per rotation: period saturates
          if (p_new != act_q) begin
            act_d   = p_new;
            phase_d = '0;
          end
          kept_d  = v_q;
          state_d = S_OUT;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          if (p_new != act_q) begin
            act_d   = p_new;
            phase_d = '0;
          end
          kept_d  = v_q;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          o_step_d    = step_q;
          o_dir_d     = dir_q;
          o_pos_d     = 32'(pos_q);
          o_mov_d     = act_q != '0;
          o_per_d     = act_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      spr_q       <= SPR_RESET;
      pos_q       <= '0;
      tgt_q       <= '0;
      act_q       <= '0;
      phase_q     <= '0;
      pulse_q     <= '0;
      step_q      <= 1'b0;
      dir_q       <= 1'b0;
      kept_q      <= KEPT_VEL_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      spr_q       <= spr_d;
      pos_q       <= pos_d;
      tgt_q       <= tgt_d;
      act_q       <= act_d;
      phase_q     <= phase_d;
      pulse_q     <= pulse_d;
      step_q      <= step_d;
      dir_q       <= dir_d;
      kept_q      <= kept_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q   <= func_d;
    rot_q    <= rot_d;
    v_q      <= v_d;
    cand_q   <= cand_d;
    prod_q   <= prod_d;
    o_step_q <= o_step_d;
    o_dir_q  <= o_dir_d;
    o_pos_q  <= o_pos_d;
    o_mov_q  <= o_mov_d;
    o_per_q  <= o_per_d;
  end

  assign cfg_ready_o  = 1'b1;
  assign in_ready_o   = state_q == S_IDLE;
  assign out_valid_o  = out_valid_q;
  assign step_level_o = o_step_q;
  assign dir_level_o  = o_dir_q;
  assign position_o   = o_pos_q;
  assign moving_o     = o_mov_q;
  assign period_us_o  = o_per_q;

  `SDG_ASSERT(a_div_done_waits, div_rsp.done |-> (state_q == S_DIV), "divider done outside wait")
  `SDG_ASSERT(a_period_floor, (act_q != '0) |-> (act_q >= MIN_P), "active period below minimum")
  `SDG_ASSERT(a_phase_range, (act_q != '0) |-> (phase_q < act_q), "phase beyond period")
  `SDG_ASSERT(a_phase_idle, (act_q == '0) |-> (phase_q == '0), "phase running while stopped")
  `SDG_ASSERT_ALWAYS(a_pulse_pin, rst_ni |-> (step_q == (pulse_q != '0)), "step pin and pulse count differ")

endmodule

@@ tb/stepper_step_dir_generator_tb.sv @@
`timescale 1ns / 100ps
// Testbench for the step/dir generator: ticks and motion commands in, one status per transaction out.
// Depends on sdg_pkg and stepper_step_dir_generator_top; self-checking against its own predictor.
module testbench;
  import sdg_pkg::*;

  localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
  localparam logic [2:0] FUNC_SPARE_7 = 3'd7;

  localparam longint POS_TOP = (longint'(1) << (POSITION_BITS_DEF - 1)) - 1;
  localparam longint POS_BOT = -POS_TOP - 1;
  localparam longint unsigned PERIOD_SAT = 64'hFFFF_FFFF;
  localparam longint unsigned TICKS_Q16 = 64'd65536000000;  // 1e6 ticks/s in Q16.16
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic               step;
    logic               dir;
    logic signed [31:0] pos;
    logic               moving;
    logic [31:0]        period;
  } motor_status_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [15:0]        cfg_steps_per_rev_i = 16'd0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [2:0]         func_i = FUNC_TICK;
  logic signed [31:0] rotations_i = '0;
  logic signed [31:0] velocity_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               step_level_o;
  logic               dir_level_o;
  logic signed [31:0] position_o;
  logic               moving_o;
  logic [31:0]        period_us_o;

  stepper_step_dir_generator_top dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_steps_per_rev_i(cfg_steps_per_rev_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .func_i             (func_i),
    .rotations_i        (rotations_i),
    .velocity_i         (velocity_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .step_level_o       (step_level_o),
    .dir_level_o        (dir_level_o),
    .position_o         (position_o),
    .moving_o           (moving_o),
    .period_us_o        (period_us_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // motor model state
  longint unsigned cur_spr;
  longint          cur_pos;
  longint          goal_pos;
  longint unsigned period_ticks;
  longint unsigned phase_ticks;
  int              pulse_left;
  bit              step_lvl;
  bit              dir_pin;
  longint          held_vel;

  motor_status_t status_due[$];
  int  errors = 0;
  int  items_sent = 0;
  int  results_checked = 0;
  int  spr_writes = 0;
  int  burst_left = 0;
  bit  sender_no_gaps = 1'b0;
  int  hold_off_request = 0;

  function automatic longint abs_of(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint rot_to_count(longint rot);
    longint unsigned s;
    s = (longint'(abs_of(rot)) * cur_spr + 64'd32768) >> 16;
    if (rot >= 0) return (s > POS_TOP) ? POS_TOP : longint'(s);
    if (s > POS_TOP + 1) return POS_BOT;
    return -longint'(s);
  endfunction

  // round-half-up division, saturated, then raised to the minimum period
  function automatic longint unsigned period_of(longint vel);
    longint unsigned den;
    longint unsigned p;
    den = cur_spr * longint'(abs_of(vel));
    if (den == 0) p = PERIOD_SAT;
    else p = (64'd2 * TICKS_Q16 + den) / (64'd2 * den);
    if (p > PERIOD_SAT) p = PERIOD_SAT;
    if (p < MIN_PERIOD_TICKS_DEF) p = MIN_PERIOD_TICKS_DEF;
    return p;
  endfunction

  function automatic void stop_motion();
    held_vel = 0;
    period_ticks = 0;
    phase_ticks = 0;
    goal_pos = cur_pos;
  endfunction

  function automatic void head_to(longint goal, longint vel);
    longint unsigned p;
    goal_pos = goal;
    if (goal == cur_pos || vel == 0) begin
      stop_motion();
      return;
    end
    dir_pin = (goal > cur_pos);
    p = period_of(vel);
    if (p != period_ticks) begin
      period_ticks = p;
      phase_ticks = 0;
    end
    held_vel = vel;
  endfunction

  function automatic void advance_tick();
    if (pulse_left != 0) begin
      pulse_left--;
      if (pulse_left == 0) step_lvl = 1'b0;
    end
    if (period_ticks == 0) return;
    phase_ticks++;
    if (phase_ticks >= period_ticks) begin
      phase_ticks = 0;
      if (goal_pos == cur_pos) begin
        period_ticks = 0;
      end else begin
        step_lvl = 1'b1;
        pulse_left = PULSE_TICKS_DEF;
        if (dir_pin) begin
          if (cur_pos < POS_TOP) cur_pos++;
        end else begin
          if (cur_pos > POS_BOT) cur_pos--;
        end
      end
    end
  endfunction

  function automatic longint offset_goal(longint rot);
    longint t;
    t = cur_pos + rot_to_count(rot);
    if (t > POS_TOP) return POS_TOP;
    if (t < POS_BOT) return POS_BOT;
    return t;
  endfunction

  function automatic motor_status_t predict_status(logic [2:0] f, logic signed [31:0] rot,
                                                   logic signed [31:0] vel);
    longint        r;
    longint        v;
    motor_status_t s;
    r = rot;
    v = vel;
    case (f)
      FUNC_TICK:     advance_tick();
      FUNC_ABS:      head_to(rot_to_count(r), v);
      FUNC_REL:      head_to(offset_goal(r), v);
      FUNC_RUN: begin
        if (v == 0) stop_motion();
        else head_to((v > 0) ? POS_TOP : POS_BOT, v);
      end
      FUNC_ABS_KEPT: head_to(rot_to_count(r), held_vel);
      FUNC_REL_KEPT: head_to(offset_goal(r), held_vel);
      default: ;
    endcase
    s.step   = step_lvl;
    s.dir    = dir_pin;
    s.pos    = cur_pos[31:0];
    s.moving = (period_ticks != 0);
    s.period = period_ticks[31:0];
    return s;
  endfunction

  function automatic void match_field(string name, longint want, longint got);
    if (want != got) begin
      errors++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    motor_status_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (status_due.size() == 0) begin
        errors++;
        $error("status transaction with nothing pending");
      end else begin
        want = status_due.pop_front();
        results_checked++;
        match_field("step_level", want.step, step_level_o);
        match_field("dir_level", want.dir, dir_level_o);
        match_field("position", want.pos, position_o);
        match_field("moving", want.moving, moving_o);
        match_field("period_us", want.period, period_us_o);
      end
    end
  end

  // receiver: rolling 16-bit ready pattern, plus long hold-offs on request
  initial begin : receiver
    logic [15:0] pattern;
    int          slot;
    int          hold_left;
    pattern = '1;
    slot = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_request != 0) begin
        hold_left = hold_off_request;
        hold_off_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        if (slot == 0)
          pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
        out_ready_i <= pattern[slot];
        slot = (slot + 1) % 16;
      end
    end
  end

  task automatic send_item(logic [2:0] f, logic signed [31:0] rot, logic signed [31:0] vel);
    int gap;
    if (burst_left == 0) begin
      if (!sender_no_gaps) begin
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 4);
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      burst_left = $urandom_range(1, 12);
    end
    in_valid_i  <= 1'b1;
    func_i      <= f;
    rotations_i <= rot;
    velocity_i  <= vel;
    do @(posedge clk_i); while (!in_ready_o);
    status_due.push_back(predict_status(f, rot, vel));
    burst_left--;
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (status_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_spr(logic [15:0] value);
    wait_drained();
    cfg_valid_i         <= 1'b1;
    cfg_steps_per_rev_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cur_spr = value;
    spr_writes++;
  endtask

  // velocity giving a short step period at the current setting
  function automatic logic signed [31:0] fast_velocity();
    longint v;
    v = TICKS_Q16 / (cur_spr * $urandom_range(4, 40));
    if (v > POS_TOP) v = POS_TOP;
    if (v == 0) v = 1;
    if ($urandom_range(0, 1)) v = -v;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] clip32(longint v);
    if (v > POS_TOP) return POS_TOP[31:0];
    if (v < POS_BOT) return POS_BOT[31:0];
    return v[31:0];
  endfunction

  task automatic test_reset_defaults();
    send_item(FUNC_TICK, 0, 0);
    send_item(FUNC_REL_KEPT, 32'sd65536, 0);      // stored 1.0 rps
    send_item(FUNC_TICK, 0, 0);
    send_item(FUNC_ABS, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    repeat (5) send_item(FUNC_TICK, 0, 0);
    send_item(FUNC_ABS, 32'sh8000_0000, 32'sh8000_0000);
    repeat (3) send_item(FUNC_TICK, 0, 0);
    send_item(FUNC_RUN, 32'sh7FFF_FFFF, 0);        // halt, stored velocity drops to 0
    send_item(FUNC_ABS_KEPT, 32'sd65536, 0);      // stored velocity 0 -> halt
    send_item(FUNC_RUN, 0, 32'sd1);
    send_item(FUNC_RUN, 0, -32'sd1);
    send_item(FUNC_REL, 0, 32'sd1000);             // already at target
    send_item(FUNC_SPARE_6, 32'(int'($urandom)), 32'(int'($urandom)));
    send_item(FUNC_SPARE_7, 32'(int'($urandom)), 32'(int'($urandom)));
  endtask

  task automatic test_spr_extremes();
    write_spr(16'd1);
    send_item(FUNC_ABS, 32'sh0000_8000, 32'sd1);   // half step rounds up, period saturates
    send_item(FUNC_ABS, -32'sh0000_8000, 32'sd1);  // rounds away from zero
    send_item(FUNC_ABS, 32'sh0000_7FFF, 32'sd1);
    send_item(FUNC_RUN, 0, 32'sh7FFF_FFFF);
    send_item(FUNC_TICK, 0, 0);
    write_spr(16'hFFFF);
    send_item(FUNC_RUN, 0, 32'sh7FFF_FFFF);
    repeat (5) send_item(FUNC_TICK, 0, 0);
    send_item(FUNC_RUN, 0, 32'sd1);
    send_item(FUNC_REL_KEPT, -32'sd65536, 0);
  endtask

  task automatic test_random_motion(int count);
    func_e  moves[5] = '{FUNC_ABS, FUNC_REL, FUNC_RUN, FUNC_ABS_KEPT, FUNC_REL_KEPT};
    int     pick;
    longint k;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      k = longint'($urandom_range(0, 16)) - 8;
      if (pick < 55) begin
        send_item(FUNC_TICK, 32'(int'($urandom)), 32'(int'($urandom)));
      end else if (pick < 66) begin
        send_item($urandom_range(0, 1) ? FUNC_REL : FUNC_REL_KEPT,
                  clip32(k * 65536 / longint'(cur_spr)), fast_velocity());
      end else if (pick < 74) begin
        send_item($urandom_range(0, 1) ? FUNC_ABS : FUNC_ABS_KEPT,
                  clip32((cur_pos + k) * 65536 / longint'(cur_spr)), fast_velocity());
      end else if (pick < 80) begin
        send_item(FUNC_RUN, 32'(int'($urandom)), fast_velocity());
      end else if (pick < 84) begin
        send_item($urandom_range(0, 1) ? FUNC_RUN : FUNC_REL, 0, 0);
      end else if (pick < 95) begin
        send_item(moves[$urandom_range(0, 4)], 32'(int'($urandom)), 32'(int'($urandom)));
      end else begin
        send_item($urandom_range(0, 1) ? FUNC_SPARE_6 : FUNC_SPARE_7,
                  32'(int'($urandom)), 32'(int'($urandom)));
      end
    end
  endtask

  // receiver stops for a long while; the sender keeps offering until the input stalls
  task automatic test_backpressure();
    hold_off_request = 400;
    sender_no_gaps = 1'b1;
    for (int i = 0; i < 20; i++)
      send_item(($urandom_range(0, 3) == 0) ? FUNC_REL : FUNC_TICK,
                clip32((longint'($urandom_range(0, 8)) - 4) * 65536 / longint'(cur_spr)),
                fast_velocity());
    sender_no_gaps = 1'b0;
  endtask

  initial begin
    cur_spr = SPR_RESET;
    cur_pos = 0;
    goal_pos = 0;
    period_ticks = 0;
    phase_ticks = 0;
    pulse_left = 0;
    step_lvl = 1'b0;
    dir_pin = 1'b0;
    held_vel = KEPT_VEL_RESET;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_spr_extremes();
    test_random_motion(130);
    write_spr(16'd1);
    test_random_motion(130);
    write_spr(SPR_RESET);
    sender_no_gaps = 1'b1;
    test_random_motion(130);
    sender_no_gaps = 1'b0;
    write_spr(16'($urandom_range(1, 65535)));
    test_backpressure();
    test_random_motion(130);
    write_spr(16'($urandom_range(1, 65535)));
    test_random_motion(130);
    wait_drained();

    $display("summary: %0d transactions sent, %0d status results checked, %0d steps-per-rev writes",
             items_sent, results_checked, spr_writes);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
